// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define VCTMC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("vctmc assertion failed");

// same, with a message of its own
`define VCTMC_ASSERT_MSG(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/vctmc_pkg.sv =====
`timescale 1ns / 1ps

package vctmc_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_BOOST_TICKS = 3'd0;
	localparam logic [2:0] CFG_STEER_TICKS = 3'd1;
	localparam logic [2:0] CFG_BRAKE_TICKS = 3'd2;
	localparam logic [2:0] CFG_BOOST_DUTY  = 3'd3;
	localparam logic [2:0] CFG_BRAKE_DUTY  = 3'd4;

	// bit positions in the line level vector
	localparam int LINE_FWD   = 0;
	localparam int LINE_BACK  = 1;
	localparam int LINE_LEFT  = 2;
	localparam int LINE_RIGHT = 3;
	localparam int LINE_LAMP  = 4;

	// timer slots, handled in this order on a tick
	localparam int TMR_FWD   = 0;
	localparam int TMR_BACK  = 1;
	localparam int TMR_STEER = 2;
	localparam int TMR_BRAKE = 3;

	// command bytes
	localparam logic [7:0] CMD_FWD    = 8'h57; // W
	localparam logic [7:0] CMD_BACK   = 8'h53; // S
	localparam logic [7:0] CMD_LEFT   = 8'h41; // A
	localparam logic [7:0] CMD_RIGHT  = 8'h44; // D
	localparam logic [7:0] CMD_CENTER = 8'h43; // C
	localparam logic [7:0] CMD_HOLD   = 8'h48; // H
	localparam logic [7:0] CMD_AUTO   = 8'h5A; // Z
	localparam logic [7:0] CMD_MANUAL = 8'h58; // X
	localparam logic [7:0] CMD_LAMP_ON  = 8'h4C; // L
	localparam logic [7:0] CMD_LAMP_OFF = 8'h4F; // O
	localparam logic [7:0] CMD_ENTRY  = 8'h50; // P

	localparam logic [7:0] DIGIT_LO = 8'd48;
	localparam logic [7:0] DIGIT_HI = 8'd57;
	localparam logic [9:0] SPEED_MAX = 10'd255;

	typedef struct packed {
		logic [7:0] boost_ticks;
		logic [7:0] steer_ticks;
		logic [7:0] brake_ticks;
		logic [7:0] boost_duty;
		logic [7:0] brake_duty;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       speed_setting;
		logic [7:0]       duty_now;
		logic             autonomous;
		logic             hold_latched;
		logic             entry_active;
		logic [1:0]       digit_count;
		logic [2:0][3:0]  digits;
		logic [4:0]       lines;
		logic [3:0]       tmr_active;
		logic [3:0][7:0]  tmr_count;
	} state_t;

	// reports raised by one item, in order of appearance
	typedef struct packed {
		logic [1:0]      count;
		logic [2:0][7:0] value;
	} rep_t;

	localparam cfg_t CFG_RESET = '{
		boost_ticks: 8'd30,
		steer_ticks: 8'd30,
		brake_ticks: 8'd8,
		boost_duty:  8'd200,
		brake_duty:  8'd255
	};

	localparam state_t STATE_RESET = '{
		speed_setting: 8'd120,
		duty_now:      8'd120,
		autonomous:    1'b1,
		hold_latched:  1'b0,
		entry_active:  1'b0,
		digit_count:   2'd0,
		digits:        '0,
		lines:         5'b10000,
		tmr_active:    4'b0000,
		tmr_count:     '0
	};

endpackage

// ===== hw/rtl/vctmc_in_if.sv =====
`timescale 1ns / 1ps

interface vctmc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

// ===== hw/rtl/vctmc_out_if.sv =====
`timescale 1ns / 1ps

interface vctmc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] drive_duty;
	logic       forward_on;
	logic       backward_on;
	logic       left_on;
	logic       right_on;
	logic       lamp_on;
	logic       report_valid;
	logic [7:0] report_value;
	logic       last;

	modport source (
		output valid, output drive_duty, output forward_on, output backward_on,
		output left_on, output right_on, output lamp_on, output report_valid,
		output report_value, output last, input ready
	);
	modport sink (
		input valid, input drive_duty, input forward_on, input backward_on,
		input left_on, input right_on, input lamp_on, input report_valid,
		input report_value, input last, output ready
	);
endinterface

// ===== hw/rtl/vctmc_step.sv =====
`timescale 1ns / 1ps

module vctmc_step (
	input  vctmc_pkg::state_t cur,
	input  vctmc_pkg::cfg_t   cfg,
	input  logic              mode,
	input  logic [7:0]        rx_byte,
	output vctmc_pkg::state_t nxt,
	output vctmc_pkg::rep_t   rep
);
	import vctmc_pkg::*;

	always_comb begin
		logic [3:0]      expire;
		logic [3:0][7:0] lim;
		logic [7:0]      cnt_inc;
		logic [9:0]      entry_val;

		nxt = cur;
		rep = '0;
		expire = '0;
		cnt_inc = '0;
		lim = {cfg.brake_ticks, cfg.steer_ticks, cfg.boost_ticks, cfg.boost_ticks};
		entry_val = 10'(cur.digits[0]) * 10'd100 + 10'(cur.digits[1]) * 10'd10
			+ 10'(cur.digits[2]);

		if (mode) begin
			for (int t = 0; t < 4; t++) begin
				cnt_inc = cur.tmr_count[t] + 8'd1;
				if (cur.tmr_active[t]) begin
					if (cnt_inc == lim[t]) begin
						expire[t] = 1'b1;
						nxt.tmr_count[t] = '0;
						nxt.tmr_active[t] = 1'b0;
					end else begin
						nxt.tmr_count[t] = cnt_inc;
					end
				end
			end
			if (expire[TMR_FWD]) begin
				rep.value[rep.count] = cur.speed_setting;
				rep.count = rep.count + 2'd1;
			end
			if (expire[TMR_BACK]) begin
				rep.value[rep.count] = cur.speed_setting;
				rep.count = rep.count + 2'd1;
			end
			if (expire[TMR_BRAKE]) begin
				rep.value[rep.count] = '0;
				rep.count = rep.count + 2'd1;
				nxt.lines[LINE_BACK] = 1'b0;
			end
			if (expire[TMR_FWD] || expire[TMR_BACK] || expire[TMR_BRAKE])
				nxt.duty_now = cur.speed_setting;
			if (expire[TMR_STEER]) begin
				nxt.lines[LINE_LEFT] = 1'b0;
				nxt.lines[LINE_RIGHT] = 1'b0;
			end
		end else if (cur.entry_active) begin
			if (cur.digit_count != 2'd3) begin
				if (rx_byte >= DIGIT_LO && rx_byte <= DIGIT_HI) begin
					// low nibble of an ascii digit is its value
					nxt.digits[cur.digit_count] = rx_byte[3:0];
					nxt.digit_count = cur.digit_count + 2'd1;
				end
			end else begin
				// any byte commits the three digits
				nxt.digit_count = '0;
				nxt.entry_active = 1'b0;
				if (entry_val <= SPEED_MAX)
					nxt.speed_setting = entry_val[7:0];
			end
		end else begin
			unique case (rx_byte)
				CMD_FWD: begin
					nxt.hold_latched = 1'b0;
					nxt.duty_now = cfg.boost_duty;
					rep.value[0] = cfg.boost_duty;
					rep.count = 2'd1;
					nxt.tmr_active[TMR_FWD] = 1'b1;
					nxt.lines[LINE_FWD] = 1'b1;
					nxt.lines[LINE_BACK] = 1'b0;
				end
				CMD_BACK: begin
					nxt.duty_now = cfg.boost_duty;
					rep.value[0] = cfg.boost_duty;
					rep.count = 2'd1;
					nxt.tmr_active[TMR_BACK] = 1'b1;
					nxt.lines[LINE_BACK] = 1'b1;
					nxt.lines[LINE_FWD] = 1'b0;
				end
				CMD_LEFT: begin
					if (!cur.autonomous)
						nxt.tmr_active[TMR_STEER] = 1'b1;
					nxt.lines[LINE_LEFT] = 1'b1;
					nxt.lines[LINE_RIGHT] = 1'b0;
				end
				CMD_RIGHT: begin
					if (!cur.autonomous)
						nxt.tmr_active[TMR_STEER] = 1'b1;
					nxt.lines[LINE_RIGHT] = 1'b1;
					nxt.lines[LINE_LEFT] = 1'b0;
				end
				CMD_CENTER: begin
					nxt.lines[LINE_LEFT] = 1'b0;
					nxt.lines[LINE_RIGHT] = 1'b0;
				end
				CMD_HOLD: begin
					if (!cur.hold_latched) begin
						nxt.duty_now = cfg.brake_duty;
						rep.value[0] = cfg.brake_duty;
						rep.count = 2'd1;
						nxt.tmr_active[TMR_BRAKE] = 1'b1;
						nxt.lines[LINE_BACK] = 1'b1;
						nxt.lines[LINE_FWD] = 1'b0;
						nxt.hold_latched = 1'b1;
					end
				end
				CMD_AUTO:     nxt.autonomous = 1'b1;
				CMD_MANUAL:   nxt.autonomous = 1'b0;
				CMD_LAMP_ON:  nxt.lines[LINE_LAMP] = 1'b1;
				CMD_LAMP_OFF: nxt.lines[LINE_LAMP] = 1'b0;
				CMD_ENTRY:    nxt.entry_active = 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/vehicle_command_timed_motor_control.sv =====
// latency: the first result of an item is shown the cycle after its transfer in
// throughput: one item per cycle when it raises at most one report and out_ready is high;
//   an item with more reports holds the result register until the single result port takes each
// reset: arst_n empties the result register and loads the power-on registers
//   (cruise 120, autonomous, lamp on, timers stopped); no clearing pass
`timescale 1ns / 1ps

module vehicle_command_timed_motor_control (
	input  logic              clk,
	input  logic              arst_n,
	vctmc_in_if.sink          in_ch,
	vctmc_out_if.source       out_ch,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data
);
	import vctmc_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	rep_t   rep;

	logic            res_valid_q;
	logic [1:0]      res_idx_q;
	logic [1:0]      res_last_q;
	logic            res_rep_q;
	logic [7:0]      res_duty_q;
	logic [4:0]      res_lines_q;
	logic [2:0][7:0] res_vals_q;

	logic res_is_last;
	logic in_xfer;
	logic out_xfer;

	vctmc_step u_step (
		.cur     (state_q),
		.cfg     (cfg_q),
		.mode    (in_ch.mode),
		.rx_byte (in_ch.rx_byte),
		.nxt     (state_nxt),
		.rep     (rep)
	);

	assign res_is_last = (res_idx_q == res_last_q);
	assign out_xfer = out_ch.valid && out_ch.ready;
	// take a new item whenever the result register empties this cycle
	assign in_ch.ready = !res_valid_q || (out_ch.ready && res_is_last);
	assign in_xfer = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOOST_TICKS: cfg_q.boost_ticks <= cfg_data;
				CFG_STEER_TICKS: cfg_q.steer_ticks <= cfg_data;
				CFG_BRAKE_TICKS: cfg_q.brake_ticks <= cfg_data;
				CFG_BOOST_DUTY:  cfg_q.boost_duty <= cfg_data;
				CFG_BRAKE_DUTY:  cfg_q.brake_duty <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			res_valid_q <= 1'b0;
			res_idx_q   <= '0;
			res_last_q  <= '0;
		end else if (in_xfer) begin
			state_q     <= state_nxt;
			res_valid_q <= 1'b1;
			res_idx_q   <= '0;
			res_last_q  <= (rep.count == 2'd0) ? 2'd0 : rep.count - 2'd1;
		end else if (out_xfer) begin
			if (res_is_last)
				res_valid_q <= 1'b0;
			else
				res_idx_q <= res_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_rep_q   <= (rep.count != 2'd0);
			res_duty_q  <= state_nxt.duty_now;
			res_lines_q <= state_nxt.lines;
			res_vals_q  <= rep.value;
		end
	end

	assign out_ch.valid        = res_valid_q;
	assign out_ch.drive_duty   = res_duty_q;
	assign out_ch.forward_on   = res_lines_q[LINE_FWD];
	assign out_ch.backward_on  = res_lines_q[LINE_BACK];
	assign out_ch.left_on      = res_lines_q[LINE_LEFT];
	assign out_ch.right_on     = res_lines_q[LINE_RIGHT];
	assign out_ch.lamp_on      = res_lines_q[LINE_LAMP];
	assign out_ch.report_valid = res_rep_q;
	assign out_ch.report_value = res_rep_q ? res_vals_q[res_idx_q] : 8'd0;
	assign out_ch.last         = res_is_last;

endmodule

// ===== hw/rtl/vctmc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vctmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] drive_duty,
	input logic       report_valid,
	input logic [7:0] report_value,
	input logic       last
);

	// a stalled result stays offered
	`VCTMC_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)

	// without a report the single result is also the last one
	`VCTMC_ASSERT_MSG(a_plain_last, clk, arst_n, out_valid && !report_valid |-> last && report_value == 8'd0, "result without report must be last and zero")

	// more results of the same item follow at once and share its duty
	`VCTMC_ASSERT_MSG(a_burst_cont, clk, arst_n, out_valid && out_ready && !last |=> out_valid && report_valid && $stable(drive_duty), "report burst broken")

	// no new transfer while a non-final result is still pending
	`VCTMC_ASSERT(a_in_block, clk, arst_n, out_valid && !last |-> !(in_valid && in_ready))

endmodule

bind vehicle_command_timed_motor_control vctmc_checker u_vctmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.drive_duty   (out_ch.drive_duty),
	.report_valid (out_ch.report_valid),
	.report_value (out_ch.report_value),
	.last         (out_ch.last)
);
